// ----- rtl/itp_pkg.sv -----
// shared types, codes and lookup functions of the infix to postfix converter
package itp_pkg;

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;

   localparam logic [2:0] CODE_OPEN  = 3'd0;
   localparam logic [2:0] CODE_PLUS  = 3'd1;
   localparam logic [2:0] CODE_MINUS = 3'd2;
   localparam logic [2:0] CODE_MUL   = 3'd3;
   localparam logic [2:0] CODE_DIV   = 3'd4;

   localparam logic [2:0] CLS_ALNUM = 3'd0;
   localparam logic [2:0] CLS_OPEN  = 3'd1;
   localparam logic [2:0] CLS_CLOSE = 3'd2;
   localparam logic [2:0] CLS_OP    = 3'd3;
   localparam logic [2:0] CLS_BAD   = 3'd4;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_OVERFLOW = 3'd1;
   localparam logic [2:0] ERR_CLOSE    = 3'd2;
   localparam logic [2:0] ERR_OPEN     = 3'd3;
   localparam logic [2:0] ERR_INVALID  = 3'd4;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0] cls;
      logic [2:0] op;
      logic [7:0] chr;
      logic       eoe;
   } item_type;

   function automatic logic [7:0] code_char(input logic [2:0] code);
      logic [7:0] c;
      c = 8'h00;
      case (code)
         CODE_OPEN:  c = CH_OPEN;
         CODE_PLUS:  c = CH_PLUS;
         CODE_MINUS: c = CH_MINUS;
         CODE_MUL:   c = CH_MUL;
         CODE_DIV:   c = CH_DIV;
         default:    c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] code_prec(input logic [2:0] code);
      logic [1:0] p;
      p = 2'd0;
      case (code) inside
         CODE_PLUS, CODE_MINUS: p = 2'd1;
         CODE_MUL, CODE_DIV:    p = 2'd2;
         default:               p = 2'd0;
      endcase
      return p;
   endfunction

endpackage

// ----- rtl/itp_channels.sv -----
// valid/ready channel interfaces for characters in and postfix results out
interface itp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_expr;
   modport source (output valid, output in_char, output end_of_expr, input ready);
   modport sink   (input valid, input in_char, input end_of_expr, output ready);
endinterface

interface itp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       has_char;
   logic       last;
   logic [2:0] error_code;
   modport source (output valid, output out_char, output has_char, output last,
                   output error_code, input ready);
   modport sink   (input valid, input out_char, input has_char, input last,
                   input error_code, output ready);
endinterface

// ----- rtl/itp_front.sv -----
// front end: accepts character beats and classifies them for the queue
module itp_front (
   itp_req_if.sink          req,
   input  logic             wr_ready,
   output logic             wr_valid,
   output itp_pkg::item_type wr_item
);
   import itp_pkg::*;

   logic [7:0] c;

   assign c        = req.in_char;
   assign req.ready = wr_ready;
   assign wr_valid = req.valid;

   always_comb begin
      wr_item.chr = c;
      wr_item.eoe = req.end_of_expr;
      wr_item.op  = CODE_OPEN;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A)) begin
         wr_item.cls = CLS_ALNUM;
      end else begin
         unique case (c) inside
            CH_OPEN:  wr_item.cls = CLS_OPEN;
            CH_CLOSE: wr_item.cls = CLS_CLOSE;
            CH_PLUS: begin
               wr_item.cls = CLS_OP;
               wr_item.op  = CODE_PLUS;
            end
            CH_MINUS: begin
               wr_item.cls = CLS_OP;
               wr_item.op  = CODE_MINUS;
            end
            CH_MUL: begin
               wr_item.cls = CLS_OP;
               wr_item.op  = CODE_MUL;
            end
            CH_DIV: begin
               wr_item.cls = CLS_OP;
               wr_item.op  = CODE_DIV;
            end
            default: wr_item.cls = CLS_BAD;
         endcase
      end
   end

endmodule

// ----- rtl/itp_queue.sv -----
// short queue of classified items between front and back
module itp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  itp_pkg::item_type wr_item,
   output logic              rd_valid,
   input  logic              rd_pop,
   output itp_pkg::item_type rd_item
);
   import itp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_wr, do_rd;

   assign wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

// ----- rtl/itp_back.sv -----
// back end: operator stack sequencer and registered result beat
module itp_back #(
   parameter int STACK_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  itp_pkg::item_type head,
   output logic              head_pop,
   itp_rsp_if.source         rsp
);
   import itp_pkg::*;

   localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   localparam logic S_CHAR  = 1'b0;
   localparam logic S_FLUSH = 1'b1;

   logic [2:0]        stack_mem [STACK_DEPTH];
   logic              state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  rd_cnt;
   logic [2:0]        top_ff, top_in;
   logic [2:0]        second_ff;
   logic              open_left_ff, open_left_in;
   logic              rsp_valid_ff;
   logic [7:0]        out_char_ff;
   logic              has_char_ff, last_ff;
   logic [2:0]        error_code_ff;

   logic              out_free, go;
   logic              want_emit, want_push, want_pop, want_done;
   logic              pop_last;
   logic [7:0]        e_char;
   logic              e_has, e_last;
   logic [2:0]        e_err;
   logic              empty, full;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(STACK_DEPTH));
   assign out_free = !rsp_valid_ff || rsp.ready;

   // work out the head item's step; take it, if it emits, only when the output can hold it
   always_comb begin
      want_emit    = 1'b0;
      want_push    = 1'b0;
      want_pop     = 1'b0;
      want_done    = 1'b0;
      pop_last     = 1'b0;
      e_char       = 8'h00;
      e_has        = 1'b0;
      e_last       = 1'b0;
      e_err        = ERR_NONE;
      open_left_in = open_left_ff;
      state_in     = state_ff;
      unique case (state_ff)
         S_CHAR: begin
            unique case (head.cls)
               CLS_ALNUM: begin
                  want_emit = 1'b1;
                  e_char    = head.chr;
                  e_has     = 1'b1;
                  want_done = 1'b1;
               end
               CLS_OPEN: begin
                  want_done = 1'b1;
                  if (full) begin
                     want_emit = 1'b1;
                     e_err     = ERR_OVERFLOW;
                  end else begin
                     want_push = 1'b1;
                  end
               end
               CLS_CLOSE: begin
                  if (empty) begin
                     want_emit = 1'b1;
                     e_err     = ERR_CLOSE;
                     want_done = 1'b1;
                  end else begin
                     want_pop = 1'b1;
                     if (top_ff == CODE_OPEN) begin
                        want_done = 1'b1;
                     end else begin
                        want_emit = 1'b1;
                        e_char    = code_char(top_ff);
                        e_has     = 1'b1;
                        pop_last  = (count_ff != CNT_W'(1)) && (second_ff == CODE_OPEN);
                     end
                  end
               end
               CLS_OP: begin
                  if (!empty && top_ff != CODE_OPEN &&
                      code_prec(top_ff) >= code_prec(head.op)) begin
                     want_pop  = 1'b1;
                     want_emit = 1'b1;
                     e_char    = code_char(top_ff);
                     e_has     = 1'b1;
                     pop_last  = (count_ff == CNT_W'(1)) || (second_ff == CODE_OPEN) ||
                                 (code_prec(second_ff) < code_prec(head.op));
                  end else begin
                     want_done = 1'b1;
                     if (full) begin
                        want_emit = 1'b1;
                        e_err     = ERR_OVERFLOW;
                     end else begin
                        want_push = 1'b1;
                     end
                  end
               end
               default: begin
                  want_emit = 1'b1;
                  e_err     = ERR_INVALID;
                  want_done = 1'b1;
               end
            endcase
            e_last = (want_done || pop_last) && !head.eoe;
            if (want_done && head.eoe) begin
               state_in     = S_FLUSH;
               open_left_in = 1'b0;
            end
         end
         S_FLUSH: begin
            if (empty) begin
               want_emit = 1'b1;
               e_last    = 1'b1;
               e_err     = open_left_ff ? ERR_OPEN : ERR_NONE;
               state_in  = S_CHAR;
            end else begin
               want_pop = 1'b1;
               if (top_ff == CODE_OPEN) begin
                  open_left_in = 1'b1;
               end else begin
                  want_emit = 1'b1;
                  e_char    = code_char(top_ff);
                  e_has     = 1'b1;
               end
            end
         end
         default: state_in = S_CHAR;
      endcase
   end

   assign go       = head_valid && (!want_emit || out_free);
   assign head_pop = go && ((state_ff == S_CHAR && want_done && !head.eoe) ||
                            (state_ff == S_FLUSH && empty));

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (go && want_pop) begin
         count_in = count_ff - CNT_W'(1);
         top_in   = second_ff;
      end else if (go && want_push) begin
         count_in = count_ff + CNT_W'(1);
         top_in   = head.op;
      end
   end

   assign rd_cnt = count_in - CNT_W'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CHAR;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            state_ff <= state_in;
         end
         count_ff <= count_in;
         if (go && want_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (go) begin
         open_left_ff <= open_left_in;
      end
      if (go && want_emit) begin
         out_char_ff   <= e_char;
         has_char_ff   <= e_has;
         last_ff       <= e_last;
         error_code_ff <= e_err;
      end
   end

   // stack store: second_ff follows the entry just below the top
   always_ff @(posedge clock) begin
      if (go && want_push) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= head.op;
      end
      second_ff <= stack_mem[rd_cnt[ADDR_W-1:0]];
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_char   = out_char_ff;
   assign rsp.has_char   = has_char_ff;
   assign rsp.last       = last_ff;
   assign rsp.error_code = error_code_ff;

endmodule

// ----- rtl/infix_to_postfix_converter.sv -----
// infix to postfix converter top level: front end, item queue and stack back end
// an accepted character beat is written into the item queue, and its result beat is registered in the back end
// pace: the stack sequencer takes a step for each character, each operator popped, each '('
// discarded at the end and the end marker; a step that emits waits for a free output slot
// reset: synchronous, clears the queue, the stack count and the output beat
// the stack store holds no reset value and needs no clearing pass
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   itp_req_if.sink   req,
   itp_rsp_if.source rsp
);
   import itp_pkg::*;

   logic     wr_valid, wr_ready;
   item_type wr_item;
   logic     head_valid, head_pop;
   item_type head;

   itp_front u_front (
      .req      (req),
      .wr_ready (wr_ready),
      .wr_valid (wr_valid),
      .wr_item  (wr_item)
   );

   itp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (wr_valid),
      .wr_ready (wr_ready),
      .wr_item  (wr_item),
      .rd_valid (head_valid),
      .rd_pop   (head_pop),
      .rd_item  (head)
   );

   itp_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .head_pop   (head_pop),
      .rsp        (rsp)
   );

endmodule
